>>> rtl/core/verlet_distance_constraint_macros.svh
// assertion macros for the verlet distance constraint checker
`ifndef VERLET_DISTANCE_CONSTRAINT_MACROS_SVH
`define VERLET_DISTANCE_CONSTRAINT_MACROS_SVH

// condition and consequence in the same cycle
`define VDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("verlet distance constraint check failed");

// consequence in the cycle after the condition
`define VDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("verlet distance constraint check failed");

`endif

>>> rtl/core/vdc_pkg.sv
// shared widths, register indexes and payload types of the distance constraint
package vdc_pkg;

  localparam int COORD_W   = 32;
  localparam int DELTA_W   = 34;
  localparam int MAG_W     = 33;
  localparam int SQ_W      = 66;
  localparam int ROOT_W    = 33;
  localparam int ACC_W     = 67;
  localparam int GAIN_W    = 32;
  localparam int PROD_W    = 65;
  localparam int MOVE_SH   = 24;
  localparam int MOVE_W    = 41;
  localparam int SUM_W     = 43;
  localparam int REST_W    = 31;
  localparam int SHARE_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_AXES  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SHARE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SHARE = 8'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_W-1:0] p1;
    logic [NUM_AXES-1:0][COORD_W-1:0] p2;
    logic [NUM_AXES-1:0][MAG_W-1:0]   dmag;
    logic [NUM_AXES-1:0]              dneg;
  } geom_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_W-1:0] p1;
    logic [NUM_AXES-1:0][COORD_W-1:0] p2;
    logic [NUM_AXES-1:0]              dneg;
    logic                             eneg;
    logic                             zero;
  } corr_t;

endpackage

>>> rtl/core/vdc_isqrt.sv
// pipelined integer square root, one root bit per stage, with sideband
module vdc_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [vdc_pkg::SQ_W-1:0]  radicand,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      out_valid,
  output logic [vdc_pkg::ROOT_W-1:0] root,
  output logic [SIDE_W-1:0]         side_out
);
  import vdc_pkg::*;

  logic              vld [ROOT_W+1];
  logic [ACC_W-1:0]  rem [ROOT_W+1];
  logic [ROOT_W-1:0] rt  [ROOT_W+1];
  logic [SIDE_W-1:0] sb  [ROOT_W+1];

  assign vld[0] = in_valid;
  assign rem[0] = {{(ACC_W-SQ_W){1'b0}}, radicand};
  assign rt[0]  = '0;
  assign sb[0]  = side_in;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic [ACC_W-1:0] trial;
    logic             take;

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    assign trial = ({{(ACC_W-ROOT_W){1'b0}}, rt[s]} << (B + 1)) + (ACC_W'(1) << (2 * B));
    assign take  = rem[s] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= take ? rem[s] - trial : rem[s];
        rt[s+1]  <= take ? (rt[s] | (ROOT_W'(1) << B)) : rt[s];
        sb[s+1]  <= sb[s];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign side_out  = sb[ROOT_W];

endmodule

>>> rtl/core/vdc_div.sv
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
module vdc_div #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [vdc_pkg::SQ_W-1:0]   numer [vdc_pkg::NUM_AXES],
  input  logic [vdc_pkg::ROOT_W-1:0] denom,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       out_valid,
  output logic [vdc_pkg::MAG_W-1:0]  quot [vdc_pkg::NUM_AXES],
  output logic [SIDE_W-1:0]          side_out
);
  import vdc_pkg::*;

  logic              vld [MAG_W+1];
  logic [ACC_W-1:0]  rem [MAG_W+1][NUM_AXES];
  logic [MAG_W-1:0]  quo [MAG_W+1][NUM_AXES];
  logic [ROOT_W-1:0] den [MAG_W+1];
  logic [SIDE_W-1:0] sb  [MAG_W+1];

  assign vld[0] = in_valid;
  assign den[0] = denom;
  assign sb[0]  = side_in;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      rem[0][a] = {{(ACC_W-SQ_W){1'b0}}, numer[a]};
      quo[0][a] = '0;
    end
  end

  // quotient stays below 2^33 since each component is no longer than the length
  for (genvar s = 0; s < MAG_W; s++) begin : g_stage
    localparam int B = MAG_W - 1 - s;
    logic [ACC_W-1:0] dsh;

    assign dsh = {{(ACC_W-ROOT_W){1'b0}}, den[s]} << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          if (rem[s][a] >= dsh) begin
            rem[s+1][a] <= rem[s][a] - dsh;
            quo[s+1][a] <= quo[s][a] | (MAG_W'(1) << B);
          end else begin
            rem[s+1][a] <= rem[s][a];
            quo[s+1][a] <= quo[s][a];
          end
        end
        den[s+1] <= den[s];
        sb[s+1]  <= sb[s];
      end
    end
  end

  assign out_valid = vld[MAG_W];
  assign side_out  = sb[MAG_W];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      quot[a] = quo[MAG_W][a];
    end
  end

endmodule

>>> rtl/core/verlet_distance_constraint.sv
// verlet distance constraint: pipelined position correction for one particle pair per word
// the pipeline has 3 front stages, 33 square root stages, 2 error stages,
// 33 divider stages, a gain multiply stage and the output register
// throughput one word per cycle; the whole pipeline holds while the output word is stalled
// synchronous reset clears all valid bits and loads the register reset values
module verlet_distance_constraint (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  vdc_pkg::coord_t                first_x,
  input  vdc_pkg::coord_t                first_y,
  input  vdc_pkg::coord_t                first_z,
  input  vdc_pkg::coord_t                second_x,
  input  vdc_pkg::coord_t                second_y,
  input  vdc_pkg::coord_t                second_z,
  output logic                           result_valid,
  input  logic                           result_stall,
  output vdc_pkg::coord_t                new_first_x,
  output vdc_pkg::coord_t                new_first_y,
  output vdc_pkg::coord_t                new_first_z,
  output vdc_pkg::coord_t                new_second_x,
  output vdc_pkg::coord_t                new_second_y,
  output vdc_pkg::coord_t                new_second_z,
  output logic                           zero_length
);
  import vdc_pkg::*;

  function automatic coord_t sat32(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(signed'(32'sh7fffffff))) begin
      return 32'sh7fffffff;
    end else if (v < SUM_W'(signed'(32'sh80000000))) begin
      return 32'sh80000000;
    end else begin
      return coord_t'(v[COORD_W-1:0]);
    end
  endfunction

  logic adv;

  // configuration
  logic [REST_W-1:0]  rest_length;
  logic [SHARE_W-1:0] tension_gain;
  logic [SHARE_W-1:0] first_share;
  logic [SHARE_W-1:0] second_share;
  logic [GAIN_W-1:0]  gain1;
  logic [GAIN_W-1:0]  gain2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length  <= REST_W'(65536);
      tension_gain <= SHARE_W'(4096);
      first_share  <= SHARE_W'(2048);
      second_share <= SHARE_W'(2048);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REST_LENGTH:  rest_length  <= cfg_data[REST_W-1:0];
        CFG_TENSION_GAIN: tension_gain <= cfg_data[SHARE_W-1:0];
        CFG_FIRST_SHARE:  first_share  <= cfg_data[SHARE_W-1:0];
        CFG_SECOND_SHARE: second_share <= cfg_data[SHARE_W-1:0];
        default: ;
      endcase
    end
  end

  // combined gains settle well before any word can reach the multiply stage
  always_ff @(posedge clk) begin
    gain1 <= GAIN_W'(tension_gain) * GAIN_W'(first_share);
    gain2 <= GAIN_W'(tension_gain) * GAIN_W'(second_share);
  end

  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // stage a: capture word, form delta
  logic                      va;
  coord_t                    a_p1 [NUM_AXES];
  coord_t                    a_p2 [NUM_AXES];
  logic signed [DELTA_W-1:0] a_d  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_p1[0] <= first_x;
      a_p1[1] <= first_y;
      a_p1[2] <= first_z;
      a_p2[0] <= second_x;
      a_p2[1] <= second_y;
      a_p2[2] <= second_z;
      a_d[0]  <= DELTA_W'(second_x) - DELTA_W'(first_x);
      a_d[1]  <= DELTA_W'(second_y) - DELTA_W'(first_y);
      a_d[2]  <= DELTA_W'(second_z) - DELTA_W'(first_z);
    end
  end

  // stage b: magnitudes and squares
  logic              vb;
  geom_t             b_geom;
  logic [SQ_W-1:0]   b_sq [NUM_AXES];
  logic [MAG_W-1:0]  a_mag [NUM_AXES];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      a_mag[k] = a_d[k][DELTA_W-1] ? MAG_W'(-a_d[k]) : MAG_W'(a_d[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        b_geom.p1[k]   <= a_p1[k];
        b_geom.p2[k]   <= a_p2[k];
        b_geom.dmag[k] <= a_mag[k];
        b_geom.dneg[k] <= a_d[k][DELTA_W-1];
        b_sq[k]        <= SQ_W'(a_mag[k]) * SQ_W'(a_mag[k]);
      end
    end
  end

  // stage c: squared length
  logic            vc;
  geom_t           c_geom;
  logic [SQ_W-1:0] c_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_geom <= b_geom;
      c_sum  <= b_sq[0] + b_sq[1] + b_sq[2];
    end
  end

  // square root
  logic              vs;
  logic [ROOT_W-1:0] s_len;
  geom_t             s_geom;

  vdc_isqrt #(
    .SIDE_W ($bits(geom_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vc),
    .radicand  (c_sum),
    .side_in   (c_geom),
    .out_valid (vs),
    .root      (s_len),
    .side_out  (s_geom)
  );

  // stage e: length error
  logic              ve;
  geom_t             e_geom;
  logic [ROOT_W-1:0] e_len;
  logic [MAG_W-1:0]  e_emag;
  logic              e_eneg;
  logic              e_zero;
  logic [ROOT_W-1:0] rest_ext;

  assign rest_ext = ROOT_W'(rest_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (adv) begin
      ve <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_geom <= s_geom;
      e_len  <= s_len;
      e_eneg <= s_len < rest_ext;
      e_emag <= (s_len < rest_ext) ? MAG_W'(rest_ext - s_len) : MAG_W'(s_len - rest_ext);
      e_zero <= s_len == '0;
    end
  end

  // stage f: dividends |d| * |error|
  logic              vf;
  corr_t             f_side;
  logic [ROOT_W-1:0] f_len;
  logic [SQ_W-1:0]   f_num [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (adv) begin
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side.p1   <= e_geom.p1;
      f_side.p2   <= e_geom.p2;
      f_side.dneg <= e_geom.dneg;
      f_side.eneg <= e_eneg;
      f_side.zero <= e_zero;
      f_len       <= e_len;
      for (int k = 0; k < NUM_AXES; k++) begin
        f_num[k] <= SQ_W'(e_geom.dmag[k]) * SQ_W'(e_emag);
      end
    end
  end

  // divide by length
  logic             vq;
  logic [MAG_W-1:0] q_quot [NUM_AXES];
  corr_t            q_side;

  vdc_div #(
    .SIDE_W ($bits(corr_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vf),
    .numer     (f_num),
    .denom     (f_len),
    .side_in   (f_side),
    .out_valid (vq),
    .quot      (q_quot),
    .side_out  (q_side)
  );

  // stage g: gain products
  logic              vg;
  corr_t             g_side;
  logic [PROD_W-1:0] g_prod1 [NUM_AXES];
  logic [PROD_W-1:0] g_prod2 [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (adv) begin
      vg <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_side <= q_side;
      for (int k = 0; k < NUM_AXES; k++) begin
        g_prod1[k] <= PROD_W'(q_quot[k]) * PROD_W'(gain1);
        g_prod2[k] <= PROD_W'(q_quot[k]) * PROD_W'(gain2);
      end
    end
  end

  // output stage: signed moves and saturation, positions held when the length is zero
  coord_t                  h_new1 [NUM_AXES];
  coord_t                  h_new2 [NUM_AXES];
  logic signed [SUM_W-1:0] mv1;
  logic signed [SUM_W-1:0] mv2;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      mv1 = signed'(SUM_W'(g_prod1[k][MOVE_SH +: MOVE_W]));
      mv2 = signed'(SUM_W'(g_prod2[k][MOVE_SH +: MOVE_W]));
      // move direction flips when delta and error have opposite signs
      if (g_side.dneg[k] != g_side.eneg) begin
        mv1 = -mv1;
        mv2 = -mv2;
      end
      if (g_side.zero) begin
        h_new1[k] = coord_t'(g_side.p1[k]);
        h_new2[k] = coord_t'(g_side.p2[k]);
      end else begin
        h_new1[k] = sat32(SUM_W'(coord_t'(g_side.p1[k])) + mv1);
        h_new2[k] = sat32(SUM_W'(coord_t'(g_side.p2[k])) - mv2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      new_first_x  <= h_new1[0];
      new_first_y  <= h_new1[1];
      new_first_z  <= h_new1[2];
      new_second_x <= h_new2[0];
      new_second_y <= h_new2[1];
      new_second_z <= h_new2[2];
      zero_length  <= g_side.zero;
    end
  end

endmodule

>>> rtl/core/vdc_checker.sv
// port-level checks of the distance constraint and their binding to the top level
`include "verlet_distance_constraint_macros.svh"

module vdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic                          item_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input vdc_pkg::coord_t               new_first_x,
  input vdc_pkg::coord_t               new_second_z,
  input logic                          zero_length
);

  // a held result word keeps its payload
  `VDC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(new_first_x) && $stable(new_second_z) && $stable(zero_length))

  // input side holds exactly when a finished word waits
  `VDC_ASSERT_NOW(a_stall_link, 1'b1, item_stall == (result_valid && result_stall))

  // pipeline comes out of reset empty
  `VDC_ASSERT_NOW(a_empty_after_reset, $past(rst), !result_valid)

  // register port never pushes back
  `VDC_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind verlet_distance_constraint vdc_checker u_checker (.*);
